// ===== src/uets_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uets_pkg
// shared types, constants and codes of the usb endpoint transfer sequencer
// ----------------------------------------------------------------------------
package uets_pkg;

    localparam int NUM_ENDPOINTS = 16;
    localparam int BUFFER_BYTES  = 4096;

    localparam int EP_AW   = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
    localparam int ALLOC_W = $clog2(BUFFER_BYTES) + 1;
    localparam int SUM_W   = ((ALLOC_W > 11) ? ALLOC_W : 11) + 1;

    localparam logic [9:0]  EP0_PACKET  = 10'd64;
    localparam logic [9:0]  SETUP_BYTES = 10'd8;
    localparam logic [10:0] CRC_BYTES   = 11'd2;
    localparam logic [10:0] RX_MAX      = 11'd1023;

    // event codes
    localparam logic [2:0] OP_OPEN      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_IN_DONE   = 3'd2;
    localparam logic [2:0] OP_OUT_DONE  = 3'd3;
    localparam logic [2:0] OP_BUS_RESET = 3'd4;
    localparam logic [2:0] OP_SETUP     = 3'd5;

    localparam logic [1:0] KIND_CONTROL = 2'd0;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } seq_state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  endpoint;
        logic        dir_in;
        logic [1:0]  ep_kind;
        logic [9:0]  max_packet;
        logic [15:0] req_bytes;
        logic [10:0] rx_len_with_crc;
    } item_t;

    // per-endpoint transfer entry
    typedef struct packed {
        logic [9:0]  psize;
        logic [15:0] len;
        logic [15:0] pos;
        logic        zld;
    } ep_xfer_t;

    // per-endpoint buffer entry
    typedef struct packed {
        logic [11:0] in_buf;
        logic [11:0] out_buf;
    } ep_buf_t;

    typedef struct packed {
        logic        arm;
        logic [9:0]  arm_length;
        logic        copy_valid;
        logic [15:0] copy_offset;
        logic [9:0]  copy_len;
        logic        complete;
        logic [15:0] complete_bytes;
    } xfer_res_t;

    typedef struct packed {
        logic        valid;
        logic        clear;
        logic [10:0] in_need;
        logic [10:0] out_need;
    } alloc_req_t;

    typedef struct packed {
        logic [ALLOC_W-1:0] in_base;
        logic [ALLOC_W-1:0] out_base;
        logic               overflow;
    } alloc_stat_t;

    typedef struct packed {
        logic        arm;
        logic [9:0]  arm_length;
        logic [11:0] buffer_ptr;
        logic [11:0] setup_ptr;
        logic        copy_valid;
        logic [15:0] copy_offset;
        logic [9:0]  copy_len;
        logic        complete;
        logic [15:0] complete_bytes;
        logic        alloc_overflow;
    } result_t;

endpackage

// ===== src/uets_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uets_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module uets_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/uets_alloc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uets_alloc
// in and out packet-buffer bump allocators with overflow check
// ----------------------------------------------------------------------------
module uets_alloc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  uets_pkg::alloc_req_t req,
    output uets_pkg::alloc_stat_t stat
);

    logic [uets_pkg::ALLOC_W-1:0] in_alloc_reg, in_alloc_next;
    logic [uets_pkg::ALLOC_W-1:0] out_alloc_reg, out_alloc_next;
    logic [uets_pkg::SUM_W-1:0]   in_sum, out_sum;
    logic                         ovf;

    always_comb begin
        stat.in_base  = req.clear ? '0 : in_alloc_reg;
        stat.out_base = req.clear ? '0 : out_alloc_reg;
        in_sum  = uets_pkg::SUM_W'(stat.in_base) + uets_pkg::SUM_W'(req.in_need);
        out_sum = uets_pkg::SUM_W'(stat.out_base) + uets_pkg::SUM_W'(req.out_need);
        ovf = (in_sum > uets_pkg::SUM_W'(uets_pkg::BUFFER_BYTES)) ||
              (out_sum > uets_pkg::SUM_W'(uets_pkg::BUFFER_BYTES));
        stat.overflow = ovf;

        in_alloc_next  = in_alloc_reg;
        out_alloc_next = out_alloc_reg;
        if (req.valid) begin
            if (ovf) begin
                // nothing advances, but a bus reset still clears
                in_alloc_next  = stat.in_base;
                out_alloc_next = stat.out_base;
            end else begin
                in_alloc_next  = in_sum[uets_pkg::ALLOC_W-1:0];
                out_alloc_next = out_sum[uets_pkg::ALLOC_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_alloc_reg  <= '0;
            out_alloc_reg <= '0;
        end else begin
            in_alloc_reg  <= in_alloc_next;
            out_alloc_reg <= out_alloc_next;
        end
    end

    // allocators never pass the buffer size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(in_alloc_reg) <= 32'(uets_pkg::BUFFER_BYTES)) &&
        (32'(out_alloc_reg) <= 32'(uets_pkg::BUFFER_BYTES)))
        else $error("allocator beyond buffer size");

    // an overflowing request without clear leaves the allocators alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (req.valid && ovf && !req.clear) |=>
            ($stable(in_alloc_reg) && $stable(out_alloc_reg)))
        else $error("allocator advanced on overflow");

endmodule

// ===== src/uets_xfer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uets_xfer
// transfer update of one endpoint entry for start, in done and out done
// ----------------------------------------------------------------------------
module uets_xfer (
    input  uets_pkg::item_t     item,
    input  uets_pkg::ep_xfer_t  ent_in,
    output uets_pkg::ep_xfer_t  ent_out,
    output uets_pkg::xfer_res_t res
);

    logic [15:0] len_e, pos_e, remain;
    logic        zld_e, active, in_path, fin;
    logic [9:0]  pkt, rx;
    logic [10:0] rx_full;
    logic [16:0] rx_sum;

    always_comb begin
        // a start resets the transfer before the first packet
        len_e = (item.op == uets_pkg::OP_START) ? item.req_bytes : ent_in.len;
        pos_e = (item.op == uets_pkg::OP_START) ? 16'd0 : ent_in.pos;
        zld_e = (item.op == uets_pkg::OP_START) ? 1'b0 : ent_in.zld;

        remain = len_e - pos_e;
        pkt    = (remain > {6'd0, ent_in.psize}) ? ent_in.psize : remain[9:0];
        active = (len_e != 16'd0) && (pos_e < len_e);

        // strip crc, clamp to a packet field
        rx_full = (item.rx_len_with_crc < uets_pkg::CRC_BYTES) ? 11'd0 :
                  item.rx_len_with_crc - uets_pkg::CRC_BYTES;
        rx      = (rx_full > uets_pkg::RX_MAX) ? 10'd1023 : rx_full[9:0];
        rx_sum  = {1'b0, pos_e} + {7'd0, rx};

        in_path = (item.op == uets_pkg::OP_IN_DONE) ||
                  ((item.op == uets_pkg::OP_START) && item.dir_in);

        ent_out       = ent_in;
        ent_out.len   = len_e;
        ent_out.pos   = pos_e;
        ent_out.zld   = zld_e;
        res           = '0;
        fin           = 1'b0;

        if ((item.op == uets_pkg::OP_START) && !item.dir_in) begin
            res.arm        = 1'b1;
            res.arm_length = ent_in.psize;
        end else if (in_path) begin
            if (zld_e) begin
                fin = 1'b1;
            end else if (active) begin
                res.arm         = 1'b1;
                res.arm_length  = pkt;
                res.copy_valid  = 1'b1;
                res.copy_offset = pos_e;
                res.copy_len    = pkt;
                ent_out.pos     = pos_e + {6'd0, pkt};
            end else begin
                fin = 1'b1;
                if (len_e == 16'd0) begin
                    res.arm     = 1'b1;
                    ent_out.zld = 1'b1;
                end
            end
        end else begin
            if (zld_e) begin
                fin = 1'b1;
            end else if (active) begin
                res.copy_valid  = 1'b1;
                res.copy_offset = pos_e;
                res.copy_len    = rx;
                ent_out.pos     = rx_sum[16] ? 16'hFFFF : rx_sum[15:0];
                if (rx != ent_in.psize) begin
                    fin = 1'b1;
                end else begin
                    res.arm        = 1'b1;
                    res.arm_length = ent_in.psize;
                end
            end else begin
                fin = 1'b1;
                if (len_e == 16'd0) begin
                    res.arm        = 1'b1;
                    res.arm_length = ent_in.psize;
                    ent_out.zld    = 1'b1;
                end
            end
        end

        // start never reports completion
        if (fin && (item.op != uets_pkg::OP_START)) begin
            res.complete       = 1'b1;
            res.complete_bytes = ent_out.pos;
        end
    end

endmodule

// ===== src/usb_endpoint_transfer_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_endpoint_transfer_sequencer_core
// usb device endpoint sequencer: allocation, packet split, completion
// ----------------------------------------------------------------------------
// Each input item is one device event (open, start transfer, in done, out
// done, bus reset, setup received) and gives exactly one result item. Per
// endpoint state lives in two small rams: a transfer ram (packet size, length,
// position, zero-length mark) and a buffer ram (in and out buffer offsets),
// each read on the accept edge and written back in the execute state. The
// accept in the idle state registers the ram read; the execute state computes
// and writes back. The next item is taken back in idle, while the previous
// result may still sit in the output register, as long as that register is
// empty or being drained. Valid bits make never-written endpoint
// entries read as zero, so no clearing pass is needed after reset. The two
// buffer allocators and the endpoint 0 setup slot are plain registers.
// ----------------------------------------------------------------------------
module usb_endpoint_transfer_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // endpoint[3:0], max_packet[13:4], req_bytes[29:14],
    // rx_len_with_crc[40:30], zero fill above
    input  logic [47:0] s_tdata,
    // op[2:0], dir_in[3], ep_kind[5:4]
    input  logic [5:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // arm_length[9:0], buffer_ptr[21:10], setup_ptr[33:22], copy_offset[49:34],
    // copy_len[59:50], complete_bytes[75:60], zero fill above
    output logic [79:0] m_tdata,
    // arm[0], copy_valid[1], complete[2], alloc_overflow[3]
    output logic [3:0]  m_tuser
);

    localparam int EP_AW    = uets_pkg::EP_AW;
    localparam int XW       = $bits(uets_pkg::ep_xfer_t);
    localparam int BW       = $bits(uets_pkg::ep_buf_t);
    localparam int NUM_EP_W = uets_pkg::NUM_ENDPOINTS;

    uets_pkg::seq_state_t state_reg, state_next;
    uets_pkg::item_t      in_item, item_reg;
    uets_pkg::result_t    res, res_reg;
    logic                 out_valid_reg;

    logic                 accept;
    logic                 in_ctrl_open;
    logic [EP_AW-1:0]     a_raddr, b_raddr, a_addr_reg, b_addr_reg;

    logic [NUM_EP_W-1:0]  a_valid_reg, a_valid_next;
    logic [NUM_EP_W-1:0]  b_valid_reg, b_valid_next;
    logic                 a_hit_reg, b_hit_reg;

    logic [XW-1:0]        a_rdata;
    logic [BW-1:0]        b_rdata;
    uets_pkg::ep_xfer_t   ent_a, ent_a_wr, xfer_ent;
    uets_pkg::ep_buf_t    ent_b, ent_b_wr;
    logic                 a_we, b_we;
    uets_pkg::xfer_res_t  xfer_res;

    uets_pkg::alloc_req_t  areq;
    uets_pkg::alloc_stat_t astat;

    logic [11:0]          setup_reg, setup_next;
    logic                 valid_ep, is_open, open_ctrl;
    logic [9:0]           open_mps;
    logic [31:0]          in_base_w, out_base_w, slot_w;

    // ------------------------------------------------------------------
    // input unpack
    // ------------------------------------------------------------------
    always_comb begin
        in_item.op              = s_tuser[2:0];
        in_item.dir_in          = s_tuser[3];
        in_item.ep_kind         = s_tuser[5:4];
        in_item.endpoint        = s_tdata[3:0];
        in_item.max_packet      = s_tdata[13:4];
        in_item.req_bytes       = s_tdata[29:14];
        in_item.rx_len_with_crc = s_tdata[40:30];
    end

    assign s_tready = (state_reg == uets_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // bus reset, setup and control open touch the endpoint 0 buffers
    assign in_ctrl_open = (in_item.op == uets_pkg::OP_OPEN) &&
                          (in_item.ep_kind == uets_pkg::KIND_CONTROL);
    assign a_raddr = (in_item.op == uets_pkg::OP_BUS_RESET) ? '0 :
                     in_item.endpoint[EP_AW-1:0];
    assign b_raddr = ((in_item.op == uets_pkg::OP_BUS_RESET) ||
                      (in_item.op == uets_pkg::OP_SETUP) || in_ctrl_open) ? '0 :
                     in_item.endpoint[EP_AW-1:0];

    // ------------------------------------------------------------------
    // endpoint state rams
    // ------------------------------------------------------------------
    uets_ram #(.WIDTH(XW), .DEPTH(uets_pkg::NUM_ENDPOINTS)) u_xfer_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_addr_reg),
        .wdata (ent_a_wr),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    uets_ram #(.WIDTH(BW), .DEPTH(uets_pkg::NUM_ENDPOINTS)) u_buf_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_addr_reg),
        .wdata (ent_b_wr),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // entries never written read as zero
    assign ent_a = a_hit_reg ? uets_pkg::ep_xfer_t'(a_rdata) : '0;
    assign ent_b = b_hit_reg ? uets_pkg::ep_buf_t'(b_rdata) : '0;

    // ------------------------------------------------------------------
    // transfer step and allocators
    // ------------------------------------------------------------------
    uets_xfer u_xfer (
        .item    (item_reg),
        .ent_in  (ent_a),
        .ent_out (xfer_ent),
        .res     (xfer_res)
    );

    assign valid_ep  = (32'(item_reg.endpoint) < 32'(uets_pkg::NUM_ENDPOINTS));
    assign is_open   = (item_reg.op == uets_pkg::OP_BUS_RESET) ||
                       ((item_reg.op == uets_pkg::OP_OPEN) && valid_ep);
    assign open_ctrl = (item_reg.op == uets_pkg::OP_BUS_RESET) ||
                       (item_reg.ep_kind == uets_pkg::KIND_CONTROL);
    assign open_mps  = (item_reg.op == uets_pkg::OP_BUS_RESET) ? uets_pkg::EP0_PACKET :
                       item_reg.max_packet;

    always_comb begin
        areq.valid    = (state_reg == uets_pkg::ST_EXEC) && is_open;
        areq.clear    = (item_reg.op == uets_pkg::OP_BUS_RESET);
        areq.in_need  = '0;
        areq.out_need = '0;
        if (open_ctrl) begin
            areq.in_need  = {1'b0, open_mps};
            areq.out_need = {1'b0, open_mps} + {1'b0, uets_pkg::SETUP_BYTES};
        end else if (item_reg.dir_in) begin
            areq.in_need  = {1'b0, open_mps};
        end else begin
            areq.out_need = {1'b0, open_mps};
        end
    end

    uets_alloc u_alloc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (areq),
        .stat    (astat)
    );

    assign in_base_w  = 32'(astat.in_base);
    assign out_base_w = 32'(astat.out_base);
    assign slot_w     = out_base_w + 32'(open_mps);

    // ------------------------------------------------------------------
    // event decode: result, write-back data
    // ------------------------------------------------------------------
    always_comb begin
        res          = '0;
        ent_a_wr     = ent_a;
        ent_b_wr     = ent_b;
        a_we         = 1'b0;
        b_we         = 1'b0;
        setup_next   = setup_reg;

        if (state_reg == uets_pkg::ST_EXEC) begin
            if (is_open) begin
                ent_a_wr.psize     = open_mps;
                a_we               = 1'b1;
                b_we               = 1'b1;
                res.alloc_overflow = astat.overflow;
                if (open_ctrl) begin
                    ent_b_wr.in_buf  = in_base_w[11:0];
                    ent_b_wr.out_buf = out_base_w[11:0];
                    setup_next       = slot_w[11:0];
                    res.arm          = 1'b1;
                    res.arm_length   = uets_pkg::SETUP_BYTES;
                    res.buffer_ptr   = in_base_w[11:0];
                end else if (item_reg.dir_in) begin
                    ent_b_wr.in_buf  = in_base_w[11:0];
                    res.buffer_ptr   = in_base_w[11:0];
                end else begin
                    ent_b_wr.out_buf = out_base_w[11:0];
                    res.buffer_ptr   = out_base_w[11:0];
                end
            end else if (item_reg.op == uets_pkg::OP_SETUP) begin
                res.arm        = 1'b1;
                res.arm_length = uets_pkg::SETUP_BYTES;
                res.buffer_ptr = ent_b.out_buf;
            end else if (valid_ep && ((item_reg.op == uets_pkg::OP_START) ||
                                      (item_reg.op == uets_pkg::OP_IN_DONE) ||
                                      (item_reg.op == uets_pkg::OP_OUT_DONE))) begin
                ent_a_wr           = xfer_ent;
                a_we               = 1'b1;
                res.arm            = xfer_res.arm;
                res.arm_length     = xfer_res.arm_length;
                res.copy_valid     = xfer_res.copy_valid;
                res.copy_offset    = xfer_res.copy_offset;
                res.copy_len       = xfer_res.copy_len;
                res.complete       = xfer_res.complete;
                res.complete_bytes = xfer_res.complete_bytes;
                if ((item_reg.op == uets_pkg::OP_IN_DONE) ||
                    ((item_reg.op == uets_pkg::OP_START) && item_reg.dir_in)) begin
                    res.buffer_ptr = ent_b.in_buf;
                end else begin
                    res.buffer_ptr = ent_b.out_buf;
                end
            end
        end
        // setup slot as it stands after this event
        res.setup_ptr = setup_next;
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (a_we) begin
            a_valid_next[a_addr_reg] = 1'b1;
        end
        if (b_we) begin
            b_valid_next[b_addr_reg] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            uets_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = uets_pkg::ST_EXEC;
                end
            end
            uets_pkg::ST_EXEC: begin
                state_next = uets_pkg::ST_IDLE;
            end
            default: begin
                state_next = uets_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= uets_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            a_valid_reg   <= '0;
            b_valid_reg   <= '0;
            setup_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            setup_reg   <= setup_next;
            if (state_reg == uets_pkg::ST_EXEC) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg   <= in_item;
            a_addr_reg <= a_raddr;
            b_addr_reg <= b_raddr;
            a_hit_reg  <= a_valid_reg[a_raddr];
            b_hit_reg  <= b_valid_reg[b_raddr];
        end
        if (state_reg == uets_pkg::ST_EXEC) begin
            res_reg <= res;
        end
    end

    // ------------------------------------------------------------------
    // result pack
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       res_reg.complete_bytes,
                       res_reg.copy_len,
                       res_reg.copy_offset,
                       res_reg.setup_ptr,
                       res_reg.buffer_ptr,
                       res_reg.arm_length};
    assign m_tuser  = {res_reg.alloc_overflow,
                       res_reg.complete,
                       res_reg.copy_valid,
                       res_reg.arm};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == uets_pkg::ST_EXEC))
        else $error("accepted item not executed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == uets_pkg::ST_EXEC) |=>
            ((state_reg == uets_pkg::ST_IDLE) && out_valid_reg))
        else $error("execute did not yield a result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == uets_pkg::ST_EXEC) |-> (!s_tready && !out_valid_reg))
        else $error("result register busy during execute");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_we || b_we) |-> (state_reg == uets_pkg::ST_EXEC))
        else $error("ram write outside execute");

endmodule

// ===== sim/usb_endpoint_transfer_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_endpoint_transfer_sequencer_core_tb
// self-checking bench for the usb endpoint transfer sequencer
// ----------------------------------------------------------------------------
// A queue of device events (directed corner cases, then random open / start /
// done sequences mixed with noise) feeds a clocked stream driver. Every
// accepted item runs through a local model of the endpoint state, and the
// result it predicts is queued. A monitor compares each result item with the
// oldest prediction. Both sides idle at random, and once the receiver holds
// off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module usb_endpoint_transfer_sequencer_core_tb;

    // reserved event codes, ignored by the block
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam logic [1:0] KIND_ISO  = 2'd1;
    localparam logic [1:0] KIND_BULK = 2'd2;
    localparam logic [1:0] KIND_INTR = 2'd3;

    localparam int STIM_ITEMS = 1450;
    localparam int HOLD_AFTER = 300;  // items accepted before the long stall
    localparam int HOLD_LEN   = 400;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [5:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [3:0]  m_tuser;

    usb_endpoint_transfer_sequencer_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // model state of the endpoints
    logic [9:0]  pkt_size    [uets_pkg::NUM_ENDPOINTS];
    logic [15:0] tr_len      [uets_pkg::NUM_ENDPOINTS];
    logic [15:0] tr_pos      [uets_pkg::NUM_ENDPOINTS];
    logic        zlp_sent    [uets_pkg::NUM_ENDPOINTS];
    logic [11:0] in_buf_ofs  [uets_pkg::NUM_ENDPOINTS];
    logic [11:0] out_buf_ofs [uets_pkg::NUM_ENDPOINTS];
    logic [11:0] setup_ofs;
    int          in_alloc_top;
    int          out_alloc_top;
    uets_pkg::result_t ev_res;   // result being built for the current event

    uets_pkg::item_t   event_q[$];      // events waiting to be offered
    uets_pkg::result_t due_results[$];  // results the block still owes
    uets_pkg::item_t   cur_event;
    int      gen_psize [uets_pkg::NUM_ENDPOINTS];  // packet sizes as the generator sees them
    int      stim_total  = 0;  // events the block acts on
    int      queued_total = 0;
    int      sent_total   = 0;
    int      checked_total = 0;
    int      bad_results  = 0;
    int      n_complete   = 0;
    int      n_copy       = 0;
    int      n_overflow   = 0;
    int      in_gap  = 0;
    int      rdy_gap = 0;
    int      hold_left = 0;
    bit      held = 1'b0;
    int      rx_cycle = 0;

    // ------------------------------------------------------------------------
    // model of the block
    // ------------------------------------------------------------------------
    function automatic void open_endpoint(input logic [3:0] ep, input logic [1:0] kind,
                                          input logic dir, input logic [9:0] mps);
        int in_need;
        int out_need;
        in_need  = 0;
        out_need = 0;
        pkt_size[ep] = mps;
        if (kind == uets_pkg::KIND_CONTROL) begin
            // control endpoints always live in the endpoint 0 buffers
            in_need  = int'(mps);
            out_need = int'(mps) + int'(uets_pkg::SETUP_BYTES);
            in_buf_ofs[0]  = 12'(in_alloc_top);
            out_buf_ofs[0] = 12'(out_alloc_top);
            setup_ofs = 12'(out_alloc_top + int'(mps));
            ev_res.arm        = 1'b1;
            ev_res.arm_length = uets_pkg::SETUP_BYTES;
            ev_res.buffer_ptr = in_buf_ofs[0];
        end else if (dir) begin
            in_need = int'(mps);
            in_buf_ofs[ep] = 12'(in_alloc_top);
            ev_res.buffer_ptr = in_buf_ofs[ep];
        end else begin
            out_need = int'(mps);
            out_buf_ofs[ep] = 12'(out_alloc_top);
            ev_res.buffer_ptr = out_buf_ofs[ep];
        end
        // an allocation that does not fit leaves both allocators alone
        if (in_alloc_top + in_need > uets_pkg::BUFFER_BYTES ||
            out_alloc_top + out_need > uets_pkg::BUFFER_BYTES)
            ev_res.alloc_overflow = 1'b1;
        else begin
            in_alloc_top  = in_alloc_top + in_need;
            out_alloc_top = out_alloc_top + out_need;
        end
    endfunction

    // returns 1 once the in transfer has nothing left to send
    function automatic bit in_packet_step(input logic [3:0] ep);
        int len;
        int pos;
        int pkt;
        len = int'(tr_len[ep]);
        pos = int'(tr_pos[ep]);
        if (zlp_sent[ep])
            return 1'b1;
        if (len > 0 && pos < len) begin
            pkt = len - pos;
            if (pkt > int'(pkt_size[ep]))
                pkt = int'(pkt_size[ep]);
            ev_res.arm         = 1'b1;
            ev_res.arm_length  = 10'(pkt);
            ev_res.copy_valid  = 1'b1;
            ev_res.copy_offset = 16'(pos);
            ev_res.copy_len    = 10'(pkt);
            tr_pos[ep] = 16'(pos + pkt);
            return 1'b0;
        end
        if (len == 0) begin
            ev_res.arm        = 1'b1;
            ev_res.arm_length = '0;
            zlp_sent[ep] = 1'b1;
        end
        return 1'b1;
    endfunction

    // returns 1 once the out transfer has ended
    function automatic bit out_packet_step(input logic [3:0] ep, input int rx);
        int len;
        int pos;
        int np;
        len = int'(tr_len[ep]);
        pos = int'(tr_pos[ep]);
        if (zlp_sent[ep])
            return 1'b1;
        if (len > 0 && pos < len) begin
            np = pos + rx;
            ev_res.copy_valid  = 1'b1;
            ev_res.copy_offset = 16'(pos);
            ev_res.copy_len    = 10'(rx);
            tr_pos[ep] = (np > 65535) ? 16'hFFFF : 16'(np);
            // a short packet ends the transfer
            if (rx != int'(pkt_size[ep]))
                return 1'b1;
            ev_res.arm        = 1'b1;
            ev_res.arm_length = pkt_size[ep];
            return 1'b0;
        end
        if (len == 0) begin
            ev_res.arm        = 1'b1;
            ev_res.arm_length = pkt_size[ep];
            zlp_sent[ep] = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic uets_pkg::result_t event_result(input uets_pkg::item_t ev);
        logic [3:0] ep;
        bit         ep_ok;
        int         rx;
        ep     = ev.endpoint;
        ep_ok  = (ev.endpoint < uets_pkg::NUM_ENDPOINTS);
        ev_res = '0;
        if (ev.op == uets_pkg::OP_BUS_RESET) begin
            in_alloc_top  = 0;
            out_alloc_top = 0;
            open_endpoint(4'd0, uets_pkg::KIND_CONTROL, 1'b0, uets_pkg::EP0_PACKET);
        end else if (ev.op == uets_pkg::OP_SETUP) begin
            ev_res.arm        = 1'b1;
            ev_res.arm_length = uets_pkg::SETUP_BYTES;
            ev_res.buffer_ptr = out_buf_ofs[0];
        end else if (ep_ok && ev.op == uets_pkg::OP_OPEN) begin
            open_endpoint(ep, ev.ep_kind, ev.dir_in, ev.max_packet);
        end else if (ep_ok && ev.op == uets_pkg::OP_START) begin
            tr_len[ep]   = ev.req_bytes;
            tr_pos[ep]   = '0;
            zlp_sent[ep] = 1'b0;
            if (ev.dir_in) begin
                ev_res.buffer_ptr = in_buf_ofs[ep];
                void'(in_packet_step(ep));
            end else begin
                ev_res.buffer_ptr = out_buf_ofs[ep];
                ev_res.arm        = 1'b1;
                ev_res.arm_length = pkt_size[ep];
            end
        end else if (ep_ok && ev.op == uets_pkg::OP_IN_DONE) begin
            ev_res.buffer_ptr = in_buf_ofs[ep];
            if (in_packet_step(ep)) begin
                ev_res.complete       = 1'b1;
                ev_res.complete_bytes = tr_pos[ep];
            end
        end else if (ep_ok && ev.op == uets_pkg::OP_OUT_DONE) begin
            // strip the crc bytes, clamp to the largest packet
            rx = (ev.rx_len_with_crc < uets_pkg::CRC_BYTES) ? 0 :
                 int'(ev.rx_len_with_crc - uets_pkg::CRC_BYTES);
            if (rx > int'(uets_pkg::RX_MAX))
                rx = int'(uets_pkg::RX_MAX);
            ev_res.buffer_ptr = out_buf_ofs[ep];
            if (out_packet_step(ep, rx)) begin
                ev_res.complete       = 1'b1;
                ev_res.complete_bytes = tr_pos[ep];
            end
        end
        ev_res.setup_ptr = setup_ofs;
        return ev_res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_event(input int op, input int ep, input int dir, input int kind,
                             input int mps, input int total, input int rxc);
        uets_pkg::item_t ev;
        ev.op              = 3'(op);
        ev.endpoint        = 4'(ep);
        ev.dir_in          = 1'(dir);
        ev.ep_kind         = 2'(kind);
        ev.max_packet      = 10'(mps);
        ev.req_bytes       = 16'(total);
        ev.rx_len_with_crc = 11'(rxc);
        event_q.push_back(ev);
        if (ev.op == uets_pkg::OP_OPEN)
            gen_psize[ev.endpoint] = int'(ev.max_packet);
        else if (ev.op == uets_pkg::OP_BUS_RESET)
            gen_psize[0] = int'(uets_pkg::EP0_PACKET);
        if (ev.op <= uets_pkg::OP_SETUP)
            stim_total++;
    endtask

    function automatic int rand_psize();
        case ($urandom_range(0, 9))
            0, 1, 2:    return 8 << $urandom_range(0, 3);
            3, 4, 5, 6: return $urandom_range(1, 64);
            7:          return $urandom_range(65, 1023);
            8:          return 1023;
            default:    return $urandom_range(0, 1) ? 0 : 512;
        endcase
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic show_result(input string tag, input uets_pkg::result_t r);
        $write("  %s arm=%0d alen=%0d buf=%0d setup=%0d copy=%0d", tag, r.arm,
               r.arm_length, r.buffer_ptr, r.setup_ptr, r.copy_valid);
        $display(" off=%0d clen=%0d done=%0d bytes=%0d ovf=%0d", r.copy_offset,
                 r.copy_len, r.complete, r.complete_bytes, r.alloc_overflow);
    endtask

    // ------------------------------------------------------------------------
    // clock, reset and run limit
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("usb_endpoint_transfer_sequencer_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver: offers queued events, models each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_gap = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                due_results.push_back(event_result(cur_event));
                sent_total <= sent_total + 1;
                offer = 1'b0;
            end
            if (!offer) begin
                if (in_gap > 0)
                    in_gap--;
                else if (event_q.size() > 0) begin
                    cur_event = event_q.pop_front();
                    // endpoint, max_packet, req_bytes, rx_len_with_crc from bit 0 up
                    s_tdata <= {7'b0, cur_event.rx_len_with_crc, cur_event.req_bytes,
                                cur_event.max_packet, cur_event.endpoint};
                    // op, dir_in, ep_kind from bit 0 up
                    s_tuser <= {cur_event.ep_kind, cur_event.dir_in, cur_event.op};
                    offer = 1'b1;
                    // every fifth stretch of items goes without gaps
                    in_gap = ((sent_total / 150) % 5 == 4) ? 0 : idle_len();
                end
            end
            s_tvalid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // receiver backpressure, with one long hold-off to fill the block
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (!held && sent_total >= HOLD_AFTER) begin
                held = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rdy_gap > 0) begin
                rdy_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ((rx_cycle / 700) % 5 != 2 && $urandom_range(0, 3) == 0)
                    rdy_gap = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: sampled mid-cycle, so the values are those the next edge takes
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : monitor
        uets_pkg::result_t got;
        uets_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.arm            = m_tuser[0];
            got.copy_valid     = m_tuser[1];
            got.complete       = m_tuser[2];
            got.alloc_overflow = m_tuser[3];
            got.arm_length     = m_tdata[9:0];
            got.buffer_ptr     = m_tdata[21:10];
            got.setup_ptr      = m_tdata[33:22];
            got.copy_offset    = m_tdata[49:34];
            got.copy_len       = m_tdata[59:50];
            got.complete_bytes = m_tdata[75:60];
            checked_total <= checked_total + 1;
            if (got.complete === 1'b1)
                n_complete++;
            if (got.copy_valid === 1'b1)
                n_copy++;
            if (got.alloc_overflow === 1'b1)
                n_overflow++;
            if (due_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("result %0d arrived with nothing expected", checked_total);
                    show_result("actual  ", got);
                end
            end else begin
                want = due_results.pop_front();
                if (got !== want) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("result %0d differs", checked_total);
                        show_result("expected", want);
                        show_result("actual  ", got);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int ep;
        int dir;
        int ps;
        int total;
        int n;
        int k;
        int rx;
        int rxc;
        int sel;

        for (int i = 0; i < uets_pkg::NUM_ENDPOINTS; i++) begin
            pkt_size[i]    = '0;
            tr_len[i]      = '0;
            tr_pos[i]      = '0;
            zlp_sent[i]    = 1'b0;
            in_buf_ofs[i]  = '0;
            out_buf_ofs[i] = '0;
            gen_psize[i]   = 0;
        end
        setup_ofs     = '0;
        in_alloc_top  = 0;
        out_alloc_top = 0;

        // directed: setup before any reset, ignored codes with all-ones and zeros
        add_event(uets_pkg::OP_SETUP, 0, 0, 0, 0, 0, 0);
        add_event(OP_RSVD6, 15, 1, KIND_INTR, 1023, 16'hFFFF, 11'h7FF);
        add_event(OP_RSVD7, 0, 0, 0, 0, 0, 0);
        add_event(uets_pkg::OP_BUS_RESET, 0, 0, 0, 0, 0, 0);
        // largest packets: the fourth in open runs past the buffer memory
        add_event(uets_pkg::OP_OPEN, 1, 1, KIND_BULK, 1023, 0, 0);
        add_event(uets_pkg::OP_OPEN, 4, 1, KIND_ISO, 1023, 0, 0);
        add_event(uets_pkg::OP_OPEN, 6, 1, KIND_INTR, 1023, 0, 0);
        add_event(uets_pkg::OP_OPEN, 7, 1, KIND_BULK, 1023, 0, 0);
        add_event(uets_pkg::OP_OPEN, 2, 0, KIND_INTR, 0, 0, 0);
        // control open on a nonzero endpoint uses the endpoint 0 buffers
        add_event(uets_pkg::OP_OPEN, 3, 0, uets_pkg::KIND_CONTROL, 32, 0, 0);
        // empty in transfer: zero-length packet, then completion only
        add_event(uets_pkg::OP_START, 1, 1, 0, 0, 0, 0);
        add_event(uets_pkg::OP_IN_DONE, 1, 0, 0, 0, 0, 0);
        add_event(uets_pkg::OP_IN_DONE, 1, 0, 0, 0, 0, 0);
        add_event(uets_pkg::OP_START, 1, 1, 0, 0, 1500, 0);
        add_event(uets_pkg::OP_IN_DONE, 1, 0, 0, 0, 0, 0);
        add_event(uets_pkg::OP_IN_DONE, 1, 0, 0, 0, 0, 0);
        // zero packet size out: an empty packet counts as full, then an oversize one
        add_event(uets_pkg::OP_START, 2, 0, 0, 0, 100, 0);
        add_event(uets_pkg::OP_OUT_DONE, 2, 0, 0, 0, 0, 1);
        add_event(uets_pkg::OP_OUT_DONE, 2, 0, 0, 0, 0, 11'h7FF);
        add_event(uets_pkg::OP_START, 3, 0, 0, 0, 0, 0);
        add_event(uets_pkg::OP_OUT_DONE, 3, 0, 0, 0, 0, 0);
        add_event(uets_pkg::OP_START, 3, 0, 0, 0, 64, 0);
        add_event(uets_pkg::OP_OUT_DONE, 3, 0, 0, 0, 0, 34);
        add_event(uets_pkg::OP_OUT_DONE, 3, 0, 0, 0, 0, 1026);
        add_event(uets_pkg::OP_SETUP, 9, 1, KIND_BULK, 0, 0, 0);
        // zero packet size in: armed with nothing, no progress
        add_event(uets_pkg::OP_START, 15, 1, 0, 0, 16'hFFFF, 0);
        add_event(uets_pkg::OP_IN_DONE, 15, 0, 0, 0, 0, 0);

        // long out transfer that saturates the position
        add_event(uets_pkg::OP_OPEN, 9, 0, KIND_BULK, 1023, 0, 0);
        add_event(uets_pkg::OP_START, 9, 0, 0, 0, 16'hFFFF, 0);
        repeat (66) add_event(uets_pkg::OP_OUT_DONE, 9, 0, 0, 0, 0, 1025);

        while (stim_total < STIM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                // noise: any code, any field
                add_event($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 1),
                          $urandom_range(0, 3), $urandom_range(0, 1023),
                          $urandom_range(0, 65535), $urandom_range(0, 2047));
            end else if (sel < 10) begin
                add_event($urandom_range(0, 1) ? uets_pkg::OP_BUS_RESET : uets_pkg::OP_SETUP,
                          $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 3),
                          $urandom_range(0, 1023), $urandom_range(0, 65535),
                          $urandom_range(0, 2047));
            end else if (sel < 25) begin
                add_event(uets_pkg::OP_OPEN, $urandom_range(0, 15), $urandom_range(0, 1),
                          $urandom_range(0, 3), rand_psize(), $urandom_range(0, 65535),
                          $urandom_range(0, 2047));
            end else if (sel < 33) begin
                // done events out of sequence
                add_event($urandom_range(0, 1) ? uets_pkg::OP_IN_DONE : uets_pkg::OP_OUT_DONE,
                          $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 3),
                          $urandom_range(0, 1023), $urandom_range(0, 65535),
                          $urandom_range(0, 2047));
            end else begin
                ep  = $urandom_range(0, 15);
                dir = $urandom_range(0, 1);
                ps  = gen_psize[ep];
                case ($urandom_range(0, 9))
                    0, 1:    total = 0;
                    2, 3:    total = ps * $urandom_range(1, 4);
                    4:       total = $urandom_range(0, 65535);
                    default: total = $urandom_range(1, 300);
                endcase
                add_event(uets_pkg::OP_START, ep, dir, $urandom_range(0, 3),
                          $urandom_range(0, 1023), total, $urandom_range(0, 2047));
                if (dir) begin
                    n = (ps == 0) ? $urandom_range(1, 3) : (total + ps - 1) / ps + 1;
                    if (n > 40)
                        n = 40;
                    n = n + (($urandom_range(0, 3) == 0) ? 1 : 0);
                    repeat (n)
                        add_event(uets_pkg::OP_IN_DONE, ep, $urandom_range(0, 1),
                                  $urandom_range(0, 3), $urandom_range(0, 1023),
                                  $urandom_range(0, 65535), $urandom_range(0, 2047));
                end else begin
                    k = 0;
                    do begin
                        if ($urandom_range(0, 9) == 0)
                            rxc = $urandom_range(0, 2047);
                        else if (ps == 0)
                            rxc = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(3, 1025);
                        else if (total - k * ps > ps)
                            rxc = ps + 2;
                        else
                            rxc = $urandom_range(0, ps + 1);
                        add_event(uets_pkg::OP_OUT_DONE, ep, $urandom_range(0, 1),
                                  $urandom_range(0, 3), $urandom_range(0, 1023),
                                  $urandom_range(0, 65535), rxc);
                        rx = (rxc < 2) ? 0 : rxc - 2;
                        if (rx > 1023)
                            rx = 1023;
                        k++;
                    end while (rx == ps && total != 0 && k < 40);
                    if ($urandom_range(0, 3) == 0)
                        add_event(uets_pkg::OP_OUT_DONE, ep, 0, 0, 0, 0,
                                  $urandom_range(0, 1025));
                end
            end
        end
        queued_total = event_q.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // one result per item, so wait until every item has been answered
        while (sent_total < queued_total || checked_total < queued_total)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d events sent, %0d results checked", sent_total, checked_total);
        $display("%0d completions, %0d buffer copies, %0d allocation overflows",
                 n_complete, n_copy, n_overflow);
        if (bad_results == 0 && due_results.size() == 0)
            $display("usb_endpoint_transfer_sequencer_core: match");
        else
            $display("usb_endpoint_transfer_sequencer_core: mismatch");
        $finish;
    end

endmodule
